/* hdl/tpq_pkg.sv */
// shared types, codes and helpers for the timer priority queue
package tpq_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int OCC_W    = $clog2(CAPACITY + 1);

    localparam logic [3:0] OP_ADD_ONCE   = 4'd0;
    localparam logic [3:0] OP_ADD_REPEAT = 4'd1;
    localparam logic [3:0] OP_ADD_DELAY  = 4'd2;
    localparam logic [3:0] OP_CANCEL     = 4'd3;
    localparam logic [3:0] OP_CANCEL_ALL = 4'd4;
    localparam logic [3:0] OP_TICK       = 4'd5;
    localparam logic [3:0] OP_QUERY      = 4'd6;
    localparam logic [3:0] OP_NEXT       = 4'd7;
    localparam logic [3:0] OP_COUNTS     = 4'd8;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic KIND_DELAY  = 1'b0;
    localparam logic KIND_TIMER  = 1'b1;
    localparam logic EV_REPLY    = 1'b0;
    localparam logic EV_EXPIRY   = 1'b1;

    localparam int FLAG_NUM  = 0;
    localparam int FLAG_CANC = 1;

    // one stored heap entry
    typedef struct packed {
        logic [47:0] due;
        logic [47:0] order;
        logic [30:0] number;
        logic [22:0] interval;
        logic [31:0] fires;
        logic [31:0] rnd;
        logic [1:0]  flags;
        logic [15:0] tag;
    } ent_t;

    localparam int ENT_W = $bits(ent_t);

    // one result word
    typedef struct packed {
        logic               event_res;
        logic [1:0]         status;
        logic               entry_kind;
        logic [30:0]        number_out;
        logic [15:0]        tag_out;
        logic [31:0]        fire_count;
        logic [22:0]        interval_out;
        logic [31:0]        round_out;
        logic               cancelled;
        logic signed [23:0] value;
        logic [6:0]         live_count;
        logic               last;
    } res_t;

    // entry memory access
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        ent_t             wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_PUSH_CHK,
        S_PUSH_CMP,
        S_POP_GO,
        S_POP_LAST,
        S_POP_CHK,
        S_POP_L,
        S_POP_R,
        S_POP_CMP,
        S_TK_FRONT,
        S_TK_ROOT,
        S_TK_FIRE,
        S_NT_FRONT,
        S_NT_ROOT,
        S_SC_RD,
        S_SC_CHK,
        S_EMIT
    } state_t;

    // heap order: earlier due first, then earlier insertion
    function automatic logic runs_ahead(input ent_t a, input ent_t b);
        return (a.due < b.due) || ((a.due == b.due) && (a.order < b.order));
    endfunction

endpackage

/* hdl/tpq_ram.sv */
// generic single-write, single-read memory with registered read data
module tpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/tpq_core.sv */
// heap sequencer: decodes commands, sifts and scans the entry memory
module tpq_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [3:0]           opcode,
    input  logic signed [23:0]   duration,
    input  logic [15:0]          tag,
    input  logic [30:0]          timer_number,
    output logic                 idle,
    output tpq_pkg::mem_req_t    mreq,
    input  logic [tpq_pkg::ENT_W-1:0] mem_rdata,
    output logic                 emit,
    output tpq_pkg::res_t        res,
    input  logic                 out_free
);
    import tpq_pkg::*;

    localparam int CW = OCC_W + 1;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    state_t emit_ret_reg, emit_ret_next;

    logic [3:0]         op_reg, op_next;
    logic signed [23:0] dur_reg, dur_next;
    logic [15:0]        tag_reg, tag_next;
    logic [30:0]        num_reg, num_next;

    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [47:0]      time_reg, time_next;
    logic [30:0]      nextnum_reg, nextnum_next;
    logic [31:0]      round_reg, round_next;
    logic [47:0]      seq_reg, seq_next;
    logic [OCC_W-1:0] idx_reg, idx_next;
    logic [OCC_W-1:0] sidx_reg, sidx_next;
    logic [OCC_W-1:0] cnt_a_reg, cnt_a_next;
    logic [OCC_W-1:0] cnt_b_reg, cnt_b_next;

    ent_t elem_reg, elem_next;
    ent_t child_reg, child_next;
    ent_t fire_reg, fire_next;
    res_t res_reg, res_next;

    ent_t             rd_ent;
    logic [CW-1:0]    l_w, r_w, occ_ext;
    logic [OCC_W-1:0] par_idx, last_idx;
    logic             has_left, has_right, push_up, right_wins, child_up;
    logic             dur_bad, full, rd_num, rd_canc, rd_late, num_hit;
    logic [47:0]      due_diff;

    // shared decisions
    assign rd_ent     = ent_t'(mem_rdata);
    assign occ_ext    = {1'b0, occ_reg};
    assign l_w        = {idx_reg, 1'b1};
    assign r_w        = l_w + CW'(1);
    assign has_left   = l_w < occ_ext;
    assign has_right  = r_w < occ_ext;
    assign par_idx    = (idx_reg - OCC_W'(1)) >> 1;
    assign last_idx   = occ_reg - OCC_W'(1);
    assign push_up    = runs_ahead(elem_reg, rd_ent);
    assign right_wins = runs_ahead(rd_ent, child_reg);
    assign child_up   = runs_ahead(child_reg, elem_reg);
    assign dur_bad    = dur_reg < 24'sd1;
    assign full       = occ_ext >= CW'(CAPACITY);
    assign rd_num     = rd_ent.flags[FLAG_NUM];
    assign rd_canc    = rd_ent.flags[FLAG_CANC];
    assign rd_late    = rd_ent.due > time_reg;
    assign num_hit    = rd_num && (rd_ent.number == num_reg);
    assign due_diff   = rd_ent.due - time_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            emit_ret_reg <= S_IDLE;
            occ_reg      <= '0;
            time_reg     <= '0;
            nextnum_reg  <= 31'd1;
            round_reg    <= '0;
            seq_reg      <= '0;
            idx_reg      <= '0;
            sidx_reg     <= '0;
            cnt_a_reg    <= '0;
            cnt_b_reg    <= '0;
            op_reg       <= OP_ADD_ONCE;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            emit_ret_reg <= emit_ret_next;
            occ_reg      <= occ_next;
            time_reg     <= time_next;
            nextnum_reg  <= nextnum_next;
            round_reg    <= round_next;
            seq_reg      <= seq_next;
            idx_reg      <= idx_next;
            sidx_reg     <= sidx_next;
            cnt_a_reg    <= cnt_a_next;
            cnt_b_reg    <= cnt_b_next;
            op_reg       <= op_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        dur_reg   <= dur_next;
        tag_reg   <= tag_next;
        num_reg   <= num_next;
        elem_reg  <= elem_next;
        child_reg <= child_next;
        fire_reg  <= fire_next;
        res_reg   <= res_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (op_reg)
                    OP_ADD_ONCE, OP_ADD_REPEAT:
                        state_next = (dur_bad || full) ? S_EMIT : S_PUSH_CHK;
                    OP_ADD_DELAY:
                        state_next = full ? S_EMIT : S_PUSH_CHK;
                    OP_CANCEL, OP_CANCEL_ALL, OP_QUERY, OP_COUNTS:
                        state_next = S_SC_RD;
                    OP_TICK:
                        state_next = S_TK_FRONT;
                    OP_NEXT:
                        state_next = S_NT_FRONT;
                    default:
                        state_next = S_EMIT;
                endcase
            end
            S_PUSH_CHK:
                state_next = (idx_reg == '0) ? ret_reg : S_PUSH_CMP;
            S_PUSH_CMP:
                state_next = push_up ? S_PUSH_CHK : ret_reg;
            S_POP_GO:
                state_next = (occ_reg == OCC_W'(1)) ? ret_reg : S_POP_LAST;
            S_POP_LAST:
                state_next = S_POP_CHK;
            S_POP_CHK:
                state_next = has_left ? S_POP_L : ret_reg;
            S_POP_L:
                state_next = has_right ? S_POP_R : S_POP_CMP;
            S_POP_R:
                state_next = S_POP_CMP;
            S_POP_CMP:
                state_next = child_up ? S_POP_CHK : ret_reg;
            S_TK_FRONT:
                state_next = (occ_reg == '0) ? S_EMIT : S_TK_ROOT;
            S_TK_ROOT:
            begin
                if (rd_canc)
                begin
                    state_next = S_POP_GO;
                end
                else if (rd_late || (CW'(cnt_b_reg) >= CW'(CAPACITY)))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_POP_GO;
                end
            end
            S_TK_FIRE:
                state_next = S_EMIT;
            S_NT_FRONT:
                state_next = (occ_reg == '0) ? S_EMIT : S_NT_ROOT;
            S_NT_ROOT:
                state_next = rd_canc ? S_POP_GO : S_EMIT;
            S_SC_RD:
                state_next = (idx_reg >= occ_reg) ? S_EMIT : S_SC_CHK;
            S_SC_CHK:
            begin
                state_next = S_SC_RD;
                if ((op_reg == OP_CANCEL) && num_hit && !rd_canc)
                begin
                    state_next = S_EMIT;
                end
                if ((op_reg == OP_QUERY) && num_hit)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
                state_next = out_free ? emit_ret_reg : S_EMIT;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath, memory access and result words
    always_comb
    begin
        logic        push_go;
        ent_t        push_ent;
        logic [30:0] num_a;
        logic [31:0] fire_f;
        logic [31:0] fire_r;

        push_go       = 1'b0;
        push_ent      = '0;
        num_a         = '0;
        fire_f        = '0;
        fire_r        = '0;
        ret_next      = ret_reg;
        emit_ret_next = emit_ret_reg;
        op_next       = op_reg;
        dur_next      = dur_reg;
        tag_next      = tag_reg;
        num_next      = num_reg;
        occ_next      = occ_reg;
        time_next     = time_reg;
        nextnum_next  = nextnum_reg;
        round_next    = round_reg;
        seq_next      = seq_reg;
        idx_next      = idx_reg;
        sidx_next     = sidx_reg;
        cnt_a_next    = cnt_a_reg;
        cnt_b_next    = cnt_b_reg;
        elem_next     = elem_reg;
        child_next    = child_reg;
        fire_next     = fire_reg;
        res_next      = res_reg;
        mreq          = '0;
        emit          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = opcode;
                    dur_next = duration;
                    tag_next = tag;
                    num_next = timer_number;
                end
            end
            S_DECODE:
            begin
                res_next      = '0;
                res_next.last = 1'b1;
                emit_ret_next = S_IDLE;
                idx_next      = '0;
                cnt_a_next    = '0;
                cnt_b_next    = '0;
                case (op_reg)
                    OP_ADD_ONCE, OP_ADD_REPEAT:
                    begin
                        res_next.entry_kind = KIND_TIMER;
                        if (dur_bad)
                        begin
                            res_next.status = ST_REJECT;
                        end
                        else if (full)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            num_a = (nextnum_reg == '0) ? 31'd1 : nextnum_reg;
                            nextnum_next        = num_a + 31'd1;
                            res_next.number_out = num_a;
                            push_go             = 1'b1;
                            push_ent.due        = time_reg + 48'(dur_reg[22:0]);
                            push_ent.number     = num_a;
                            push_ent.interval   = (op_reg == OP_ADD_REPEAT) ?
                                                  dur_reg[22:0] : 23'd0;
                            push_ent.flags[FLAG_NUM] = 1'b1;
                            ret_next            = S_EMIT;
                        end
                    end
                    OP_ADD_DELAY:
                    begin
                        res_next.entry_kind = KIND_DELAY;
                        if (full)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            push_go      = 1'b1;
                            push_ent.due = time_reg +
                                           ((dur_reg > 24'sd0) ? 48'(dur_reg[22:0]) : 48'd0);
                            push_ent.tag = tag_reg;
                            ret_next     = S_EMIT;
                        end
                    end
                    OP_CANCEL, OP_CANCEL_ALL, OP_QUERY, OP_COUNTS:
                    begin
                    end
                    OP_TICK:
                        time_next = time_reg + 48'd1;
                    OP_NEXT:
                    begin
                    end
                    default:
                        res_next.status = ST_REJECT;
                endcase
            end

            // sift up with the new entry held in elem_reg
            S_PUSH_CHK:
            begin
                if (idx_reg == '0)
                begin
                    mreq.we    = 1'b1;
                    mreq.waddr = '0;
                    mreq.wdata = elem_reg;
                end
                else
                begin
                    mreq.raddr = par_idx[IDX_W-1:0];
                end
            end
            S_PUSH_CMP:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = idx_reg[IDX_W-1:0];
                if (push_up)
                begin
                    mreq.wdata = rd_ent;
                    idx_next   = par_idx;
                end
                else
                begin
                    mreq.wdata = elem_reg;
                end
            end

            // remove the root, last entry sifts down from the top
            S_POP_GO:
            begin
                occ_next   = last_idx;
                mreq.raddr = last_idx[IDX_W-1:0];
            end
            S_POP_LAST:
            begin
                elem_next = rd_ent;
                idx_next  = '0;
            end
            S_POP_CHK:
            begin
                if (has_left)
                begin
                    mreq.raddr = l_w[IDX_W-1:0];
                end
                else
                begin
                    mreq.we    = 1'b1;
                    mreq.waddr = idx_reg[IDX_W-1:0];
                    mreq.wdata = elem_reg;
                end
            end
            S_POP_L:
            begin
                child_next = rd_ent;
                sidx_next  = l_w[OCC_W-1:0];
                mreq.raddr = r_w[IDX_W-1:0];
            end
            S_POP_R:
            begin
                if (right_wins)
                begin
                    child_next = rd_ent;
                    sidx_next  = r_w[OCC_W-1:0];
                end
            end
            S_POP_CMP:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = idx_reg[IDX_W-1:0];
                if (child_up)
                begin
                    mreq.wdata = child_reg;
                    idx_next   = sidx_reg;
                end
                else
                begin
                    mreq.wdata = elem_reg;
                end
            end

            // tick: drain due entries from the front
            S_TK_FRONT:
            begin
                res_next       = '0;
                res_next.last  = 1'b1;
                res_next.value = 24'(cnt_b_reg);
                emit_ret_next  = S_IDLE;
            end
            S_TK_ROOT:
            begin
                if (rd_canc)
                begin
                    ret_next = S_TK_FRONT;
                end
                else if (!(rd_late || (CW'(cnt_b_reg) >= CW'(CAPACITY))))
                begin
                    fire_next = rd_ent;
                    ret_next  = S_TK_FIRE;
                end
            end
            S_TK_FIRE:
            begin
                cnt_b_next         = cnt_b_reg + OCC_W'(1);
                res_next           = '0;
                res_next.event_res = EV_EXPIRY;
                emit_ret_next      = S_TK_FRONT;
                if (fire_reg.flags[FLAG_NUM])
                begin
                    fire_f                = fire_reg.fires + 32'd1;
                    fire_r                = round_reg + 32'd1;
                    round_next            = fire_r;
                    res_next.entry_kind   = KIND_TIMER;
                    res_next.number_out   = fire_reg.number;
                    res_next.fire_count   = fire_f;
                    res_next.interval_out = fire_reg.interval;
                    res_next.round_out    = fire_r;
                    if (fire_reg.interval != '0)
                    begin
                        push_go           = 1'b1;
                        push_ent.due      = time_reg + 48'(fire_reg.interval);
                        push_ent.number   = fire_reg.number;
                        push_ent.interval = fire_reg.interval;
                        push_ent.fires    = fire_f;
                        push_ent.rnd      = fire_r;
                        push_ent.flags[FLAG_NUM] = 1'b1;
                        ret_next          = S_TK_FRONT;
                        emit_ret_next     = S_PUSH_CHK;
                    end
                end
                else
                begin
                    res_next.entry_kind = KIND_DELAY;
                    res_next.tag_out    = fire_reg.tag;
                    res_next.round_out  = round_reg;
                end
            end

            // next timeout after purging cancelled front entries
            S_NT_FRONT:
            begin
                res_next.value = -24'sd1;
            end
            S_NT_ROOT:
            begin
                if (rd_canc)
                begin
                    ret_next = S_NT_FRONT;
                end
                else if (!rd_late)
                begin
                    res_next.value = '0;
                end
                else if (due_diff[47:23] != '0)
                begin
                    res_next.value = 24'sh7FFFFF;
                end
                else
                begin
                    res_next.value = 24'(due_diff[22:0]);
                end
            end

            // linear scan over the stored entries
            S_SC_RD:
            begin
                mreq.raddr = idx_reg[IDX_W-1:0];
                if (idx_reg >= occ_reg)
                begin
                    case (op_reg)
                        OP_CANCEL:
                        begin
                            res_next.status     = ST_REJECT;
                            res_next.entry_kind = KIND_TIMER;
                        end
                        OP_CANCEL_ALL:
                        begin
                            res_next.entry_kind = KIND_TIMER;
                            res_next.value      = 24'(cnt_a_reg);
                        end
                        OP_QUERY:
                            res_next.status = ST_REJECT;
                        default:
                        begin
                            res_next.round_out  = round_reg;
                            res_next.value      = 24'(cnt_a_reg);
                            res_next.live_count = 7'(cnt_b_reg);
                        end
                    endcase
                end
            end
            S_SC_CHK:
            begin
                idx_next   = idx_reg + OCC_W'(1);
                mreq.waddr = idx_reg[IDX_W-1:0];
                mreq.wdata = rd_ent;
                mreq.wdata.flags[FLAG_CANC] = 1'b1;
                case (op_reg)
                    OP_CANCEL:
                    begin
                        if (num_hit && !rd_canc)
                        begin
                            mreq.we             = 1'b1;
                            res_next.entry_kind = KIND_TIMER;
                            res_next.number_out = num_reg;
                        end
                    end
                    OP_CANCEL_ALL:
                    begin
                        if (rd_num && !rd_canc)
                        begin
                            mreq.we    = 1'b1;
                            cnt_a_next = cnt_a_reg + OCC_W'(1);
                        end
                    end
                    OP_QUERY:
                    begin
                        if (num_hit)
                        begin
                            res_next.entry_kind   = KIND_TIMER;
                            res_next.number_out   = num_reg;
                            res_next.fire_count   = rd_ent.fires;
                            res_next.interval_out = rd_ent.interval;
                            res_next.round_out    = rd_ent.rnd;
                            res_next.cancelled    = rd_canc;
                        end
                    end
                    default:
                    begin
                        if (!rd_canc)
                        begin
                            cnt_a_next = cnt_a_reg + OCC_W'(1);
                            if (rd_num)
                            begin
                                cnt_b_next = cnt_b_reg + OCC_W'(1);
                            end
                        end
                    end
                endcase
            end

            S_EMIT:
                emit = out_free;
            default:
            begin
            end
        endcase

        // start a sift-up at the first free slot
        if (push_go)
        begin
            elem_next       = push_ent;
            elem_next.order = seq_reg + 48'd1;
            seq_next        = seq_reg + 48'd1;
            idx_next        = occ_reg;
            occ_next        = occ_reg + OCC_W'(1);
        end
    end

    // root reads for tick and next timeout
    // (S_TK_FRONT and S_NT_FRONT read slot zero, the default address)

    assign idle = state_reg == S_IDLE;
    assign res  = res_reg;

endmodule

/* hdl/timer_priority_queue_top.sv */
// timer priority queue: entry memory, heap sequencer and output register
// An add sifts the new entry up through the heap levels; cancel, query and counts scan the
// stored entries in order; each root removal sifts the last entry down from the top.
// A tick removes, emits and, for a repeating timer, re-arms each due entry in turn.
// One item is worked at a time; the single read port of the entry memory sets the pace.
// Reset clears control, time, counters and occupancy; the entry memory is not cleared.
module timer_priority_queue_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         opcode,
    input  logic signed [23:0] duration,
    input  logic [15:0]        tag,
    input  logic [30:0]        timer_number,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               event_res,
    output logic [1:0]         status,
    output logic               entry_kind,
    output logic [30:0]        number_out,
    output logic [15:0]        tag_out,
    output logic [31:0]        fire_count,
    output logic [22:0]        interval_out,
    output logic [31:0]        round_out,
    output logic               cancelled,
    output logic signed [23:0] value,
    output logic [6:0]         live_count,
    output logic               last
);
    import tpq_pkg::*;

    logic                idle;
    logic                emit;
    logic                out_free;
    mem_req_t            mreq;
    logic [ENT_W-1:0]    mem_rdata;
    res_t                res;
    res_t                out_word_reg;
    logic                out_valid_reg;

    // entry memory
    tpq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mreq.we),
        .waddr (mreq.waddr),
        .wdata (mreq.wdata),
        .raddr (mreq.raddr),
        .rdata (mem_rdata)
    );

    // sequencer
    tpq_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .opcode       (opcode),
        .duration     (duration),
        .tag          (tag),
        .timer_number (timer_number),
        .idle         (idle),
        .mreq         (mreq),
        .mem_rdata    (mem_rdata),
        .emit         (emit),
        .res          (res),
        .out_free     (out_free)
    );

    assign in_stall = !idle;
    assign out_free = !out_valid_reg || !out_stall;

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_word_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = out_word_reg.event_res;
    assign status       = out_word_reg.status;
    assign entry_kind   = out_word_reg.entry_kind;
    assign number_out   = out_word_reg.number_out;
    assign tag_out      = out_word_reg.tag_out;
    assign fire_count   = out_word_reg.fire_count;
    assign interval_out = out_word_reg.interval_out;
    assign round_out    = out_word_reg.round_out;
    assign cancelled    = out_word_reg.cancelled;
    assign value        = out_word_reg.value;
    assign live_count   = out_word_reg.live_count;
    assign last         = out_word_reg.last;

endmodule

/* hdl/tpq_checker.sv */
// port-level checks for the timer priority queue, bound to the top level
module tpq_port_checks (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               event_res,
    input logic [1:0]         status,
    input logic [30:0]        number_out,
    input logic signed [23:0] value,
    input logic               last
);
    import tpq_pkg::*;

    // a stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(number_out) && $stable(value)
        && $stable(last))
        else $error("stalled result word changed");

    // one command at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a command is in progress");

    // an expiry is never the closing word
    a_exp_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_EXPIRY |-> !last && status == ST_OK)
        else $error("expiry word marked last or not ok");

    // status code stays in range
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_OK || status == ST_REJECT || status == ST_FULL)
        else $error("bad status code");

endmodule

bind timer_priority_queue_top tpq_port_checks u_tpq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_res  (event_res),
    .status     (status),
    .number_out (number_out),
    .value      (value),
    .last       (last)
);
